/* rtl/pftn_pkg.sv */
// ============================================================================
// Fan triangulator package
// Shared types and fixed field widths for the fan triangulator with normals.
// ============================================================================
package pftn_pkg;

    localparam int IN_COORD_W = 16;
    localparam int VNUM_W     = 13;
    localparam int CORNER_W   = 12;
    localparam int NORMAL_W   = 35;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_INDEX = 1'b1;

    // Position inside the current fan.
    typedef enum logic [1:0] {
        FAN_FIRST,
        FAN_SECOND,
        FAN_EMIT
    } fan_state_t;

    // What the read data of the vertex store, which arrives with this command, is used for.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_FIRST,
        ACT_PREV,
        ACT_EMIT,
        ACT_BAD
    } act_t;

    typedef struct packed {
        act_t                act;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
    } tri_cmd_t;

endpackage

/* rtl/pftn_vstore.sv */
// ============================================================================
// Vertex store
// One write port for loaded vertices, one registered read port for indices.
// ============================================================================
module pftn_vstore #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 48
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/pftn_ctrl.sv */
// ============================================================================
// Fan control
// Vertex count, range check, fan sequencing and store addressing.
// ============================================================================
module pftn_ctrl
    import pftn_pkg::*;
#(
    parameter int MAX_VERTICES = 4096,
    parameter int AW           = 12,
    parameter int CW           = 13
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              accept,
    input  logic              op,
    input  logic [VNUM_W-1:0] vertex_number,
    input  logic              polygon_end,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [AW-1:0]     rd_addr,
    output tri_cmd_t          cmd
);

    localparam int CMPW = (CW > VNUM_W) ? CW : VNUM_W;

    fan_state_t        fan_reg, fan_next;
    logic              skip_reg, skip_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     first_reg, first_next;
    logic [AW-1:0]     prev_reg, prev_next;
    tri_cmd_t          cmd_reg, cmd_next;
    logic [VNUM_W-1:0] idx_full;
    logic [AW-1:0]     idx;
    logic              bad;

    assign idx_full = vertex_number - 1'b1;
    assign idx      = AW'(idx_full);
    assign bad      = (vertex_number == '0) || (CMPW'(vertex_number) > CMPW'(count_reg));
    assign wr_addr  = count_reg[AW-1:0];
    assign rd_addr  = idx;
    assign cmd      = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fan_reg   <= FAN_FIRST;
            skip_reg  <= 1'b0;
            count_reg <= '0;
            first_reg <= '0;
            prev_reg  <= '0;
            cmd_reg   <= '{act: ACT_NONE, default: '0};
        end else if (adv) begin
            fan_reg   <= fan_next;
            skip_reg  <= skip_next;
            count_reg <= count_next;
            first_reg <= first_next;
            prev_reg  <= prev_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_comb begin
        fan_next   = fan_reg;
        skip_next  = skip_reg;
        count_next = count_reg;
        first_next = first_reg;
        prev_next  = prev_reg;
        cmd_next   = '{act: ACT_NONE, default: '0};
        wr_en      = 1'b0;
        if (accept) begin
            if (op == OP_LOAD) begin
                // A full store drops the load silently.
                if (count_reg < CW'(MAX_VERTICES)) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end else if (skip_reg) begin
                if (polygon_end) begin
                    skip_next = 1'b0;
                    fan_next  = FAN_FIRST;
                end
            end else if (bad) begin
                cmd_next.act = ACT_BAD;
                skip_next    = !polygon_end;
                fan_next     = FAN_FIRST;
            end else begin
                unique case (fan_reg)
                    FAN_FIRST: begin
                        first_next   = idx;
                        fan_next     = FAN_SECOND;
                        cmd_next.act = ACT_FIRST;
                    end
                    FAN_SECOND: begin
                        prev_next    = idx;
                        fan_next     = FAN_EMIT;
                        cmd_next.act = ACT_PREV;
                    end
                    FAN_EMIT: begin
                        prev_next         = idx;
                        cmd_next.act      = ACT_EMIT;
                        cmd_next.corner_a = CORNER_W'(first_reg);
                        cmd_next.corner_b = CORNER_W'(prev_reg);
                        cmd_next.corner_c = CORNER_W'(idx);
                    end
                    default: begin
                        fan_next = FAN_FIRST;
                    end
                endcase
                if (polygon_end) begin
                    fan_next = FAN_FIRST;
                end
            end
        end
    end

endmodule

/* rtl/pftn_normal.sv */
// ============================================================================
// Face normal pipeline
// Holds the fan's first and previous vertices and forms the cross product.
// ============================================================================
module pftn_normal
    import pftn_pkg::*;
#(
    parameter int CB = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  tri_cmd_t                   cmd,
    input  logic [3*CB-1:0]            rd_data,
    output logic                       res_valid,
    output logic                       res_bad,
    output logic [CORNER_W-1:0]        res_a,
    output logic [CORNER_W-1:0]        res_b,
    output logic [CORNER_W-1:0]        res_c,
    output logic signed [2*CB+2:0]     res_nx,
    output logic signed [2*CB+2:0]     res_ny,
    output logic signed [2*CB+2:0]     res_nz
);

    localparam int DFW = CB + 1;
    localparam int PW  = 2 * CB + 2;
    localparam int NW  = 2 * CB + 3;

    logic [3*CB-1:0] first_reg;
    logic [3*CB-1:0] prev_reg;

    logic signed [DFW-1:0] fx, fy, fz, px, py, pz, cx, cy, cz;
    logic signed [DFW-1:0] ux_reg, uy_reg, uz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [PW-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;

    logic                v2_reg, v3_reg;
    logic                bad2_reg, bad3_reg;
    logic [CORNER_W-1:0] a2_reg, b2_reg, c2_reg, a3_reg, b3_reg, c3_reg;
    logic                s1_valid, s1_bad;

    assign fx = $signed({first_reg[CB-1],     first_reg[CB-1:0]});
    assign fy = $signed({first_reg[2*CB-1],   first_reg[2*CB-1:CB]});
    assign fz = $signed({first_reg[3*CB-1],   first_reg[3*CB-1:2*CB]});
    assign px = $signed({prev_reg[CB-1],      prev_reg[CB-1:0]});
    assign py = $signed({prev_reg[2*CB-1],    prev_reg[2*CB-1:CB]});
    assign pz = $signed({prev_reg[3*CB-1],    prev_reg[3*CB-1:2*CB]});
    assign cx = $signed({rd_data[CB-1],       rd_data[CB-1:0]});
    assign cy = $signed({rd_data[2*CB-1],     rd_data[2*CB-1:CB]});
    assign cz = $signed({rd_data[3*CB-1],     rd_data[3*CB-1:2*CB]});

    assign s1_bad   = (cmd.act == ACT_BAD);
    assign s1_valid = (cmd.act == ACT_EMIT) || s1_bad;

    // The fan corners live here so that each index costs one store read.
    always_ff @(posedge aclk) begin
        if (adv) begin
            case (cmd.act)
                ACT_FIRST:          first_reg <= rd_data;
                ACT_PREV, ACT_EMIT: prev_reg  <= rd_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= s1_valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // A flagged result carries zero differences, so its normal is zero.
            if (s1_bad) begin
                ux_reg <= '0;
                uy_reg <= '0;
                uz_reg <= '0;
                wx_reg <= '0;
                wy_reg <= '0;
                wz_reg <= '0;
            end else begin
                ux_reg <= fx - px;
                uy_reg <= fy - py;
                uz_reg <= fz - pz;
                wx_reg <= cx - px;
                wy_reg <= cy - py;
                wz_reg <= cz - pz;
            end
            bad2_reg <= s1_bad;
            a2_reg   <= cmd.corner_a;
            b2_reg   <= cmd.corner_b;
            c2_reg   <= cmd.corner_c;

            p0_reg   <= uy_reg * wz_reg;
            p1_reg   <= uz_reg * wy_reg;
            p2_reg   <= uz_reg * wx_reg;
            p3_reg   <= ux_reg * wz_reg;
            p4_reg   <= ux_reg * wy_reg;
            p5_reg   <= uy_reg * wx_reg;
            bad3_reg <= bad2_reg;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            c3_reg   <= c2_reg;
        end
    end

    assign res_valid = v3_reg;
    assign res_bad   = bad3_reg;
    assign res_a     = a3_reg;
    assign res_b     = b3_reg;
    assign res_c     = c3_reg;
    assign res_nx    = NW'(p0_reg) - NW'(p1_reg);
    assign res_ny    = NW'(p2_reg) - NW'(p3_reg);
    assign res_nz    = NW'(p4_reg) - NW'(p5_reg);

endmodule

/* rtl/polygon_fan_triangulator_normals.sv */
// ============================================================================
// Polygon fan triangulator with face normals
// A triangle word passes the read, difference, product and output registers
// after its index is accepted. Throughput: one word per cycle, load or index,
// unless the sink stalls; each index takes one read on the store's one read port.
// Reset clears the vertex count and fan state; the store is not cleared.
// ============================================================================
module polygon_fan_triangulator_normals
    import pftn_pkg::*;
#(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_BITS   = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Slave side.
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0: coord_x[15:0], coord_y[15:0], coord_z[15:0],
    // vertex_number[12:0], then three zero bits.
    input  logic [63:0]  s_tdata,
    // Fields from bit 0: op (0 = load vertex, 1 = polygon index).
    input  logic         s_tuser,
    // Marks the last index word of a polygon.
    input  logic         s_tlast,
    // Master side.
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0: corner_a[11:0], corner_b[11:0], corner_c[11:0],
    // normal_x[34:0], normal_y[34:0], normal_z[34:0], then three zero bits.
    output logic [143:0] m_tdata,
    // Fields from bit 0: bad_index.
    output logic         m_tuser
);

    // Store geometry follows from the vertex limit; the count holds the limit itself.
    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int CB  = COORD_BITS;
    localparam int NW  = 2 * CB + 3;

    // The whole pipeline moves together; it stalls only while a finished
    // word waits in the output register and the sink is not ready. A word
    // in the output register never blocks the input when the sink takes it.
    logic adv;
    logic accept;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [3*CB-1:0] wr_data;
    logic [3*CB-1:0] rd_data;
    tri_cmd_t      cmd;

    logic                   res_valid;
    logic                   res_bad;
    logic [CORNER_W-1:0]    res_a, res_b, res_c;
    logic signed [NW-1:0]   res_nx, res_ny, res_nz;

    logic                   m_valid_reg;
    logic                   m_bad_reg;
    logic [CORNER_W-1:0]    m_a_reg, m_b_reg, m_c_reg;
    logic [NORMAL_W-1:0]    m_nx_reg, m_ny_reg, m_nz_reg;

    // Takes the low COORD_BITS bits of a coordinate field; bits above the
    // field's width read as zero.
    function automatic logic [CB-1:0] take_coord(input logic [IN_COORD_W-1:0] v);
        logic [CB-1:0] r;
        for (int i = 0; i < CB; i++) begin
            r[i] = (i < IN_COORD_W) ? v[i] : 1'b0;
        end
        return r;
    endfunction

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    assign wr_data = {take_coord(s_tdata[47:32]),
                      take_coord(s_tdata[31:16]),
                      take_coord(s_tdata[15:0])};

    // Stage 0: range check, fan sequencing and the store address.
    pftn_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .accept        (accept),
        .op            (s_tuser),
        .vertex_number (s_tdata[60:48]),
        .polygon_end   (s_tlast),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .cmd           (cmd)
    );

    // A load is written at its own accept edge, so an index word in the
    // very next cycle already reads the new vertex; no forwarding is needed.
    pftn_vstore #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .DW    (3 * CB)
    ) u_vstore (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Stages 1 to 3: differences, six products, then the final subtraction.
    pftn_normal #(
        .CB (CB)
    ) u_normal (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cmd       (cmd),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_bad   (res_bad),
        .res_a     (res_a),
        .res_b     (res_b),
        .res_c     (res_c),
        .res_nx    (res_nx),
        .res_ny    (res_ny),
        .res_nz    (res_nz)
    );

    // Output register toward the master side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_bad_reg <= res_bad;
            m_a_reg   <= res_a;
            m_b_reg   <= res_b;
            m_c_reg   <= res_c;
            m_nx_reg  <= NORMAL_W'(res_nx);
            m_ny_reg  <= NORMAL_W'(res_ny);
            m_nz_reg  <= NORMAL_W'(res_nz);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_bad_reg;
    assign m_tdata  = {3'b000, m_nz_reg, m_ny_reg, m_nx_reg, m_c_reg, m_b_reg, m_a_reg};

endmodule
